>>> rtl/core/serial_frame_decoder_assert.svh
// Assertion macros shared by the frame decoder front end and result queue.
`ifndef SERIAL_FRAME_DECODER_ASSERT_SVH
`define SERIAL_FRAME_DECODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SFD_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SFD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/sfd_pkg.sv
// Shared types and constants of the serial frame decoder.
`timescale 1ns / 1ps

package sfd_pkg;

    localparam int unsigned MAX_PAYLOAD = 128;
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] START_BYTE_RST = 8'hFE;
    localparam logic [7:0] CHECKSUM_SEED_RST = 8'hFE;

    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_START_BYTE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHECKSUM_SEED = 1'd1;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_FRAME_END = 1'b1;

    localparam int unsigned TDATA_W = 56;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  data_byte;
        logic [6:0]  byte_index;
        logic [15:0] function_code;
        logic [15:0] payload_length;
        logic        frame_ok;
        logic        too_long;
    } sfd_result_t;

endpackage

>>> rtl/core/serial_frame_decoder.sv
// Top level of the serial frame decoder: parser, result queue and output stage.
//
//   Channel   Direction  Beat content
//   s_        in         one received byte
//   m_        out        payload byte or end-of-frame report
//   cfg_      in         register write (0 start byte, 1 checksum seed)
//
// One byte is accepted every cycle; s_tready drops only when all QUEUE_DEPTH
// queue entries hold results that the master side has not yet taken.
// A result is written into the queue at the edge that accepts its byte, and moves
// to the output register once that register is empty or its beat is taken.
// Header bytes and payload bytes past the buffer size cause no beat.
// Reset is synchronous; there is no clearing pass.
`timescale 1ns / 1ps

module serial_frame_decoder
    import sfd_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,    // rx_byte[7:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [TDATA_W-1:0]   m_tdata,    // data_byte[7:0], byte_index[14:8],
                                             // function_code[30:15],
                                             // payload_length[46:31], frame_ok[47],
                                             // too_long[48], zero pad[55:49]
    output logic                 m_tuser,    // result_kind[0]
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    logic        accept;
    logic        push;
    logic        full;
    logic        pop;
    logic        q_valid;
    sfd_result_t front_result;
    sfd_result_t q_data;

    assign cfg_ready = 1'b1;
    assign s_tready  = !full;
    assign accept    = s_tvalid && s_tready;

    sfd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we_i    (cfg_valid && cfg_ready),
        .cfg_index_i (cfg_index),
        .cfg_data_i  (cfg_data),
        .accept_i    (accept),
        .rx_byte_i   (s_tdata),
        .push_o      (push),
        .result_o    (front_result)
    );

    sfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_i  (push),
        .data_i  (front_result),
        .full_o  (full),
        .pop_i   (pop),
        .valid_o (q_valid),
        .data_o  (q_data)
    );

    sfd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid_i (q_valid),
        .q_data_i  (q_data),
        .q_pop_o   (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

>>> rtl/core/sfd_front.sv
// Front end: configuration registers and the frame parser that produces result beats.
`timescale 1ns / 1ps

module sfd_front
    import sfd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we_i,
    input  logic [CFG_IDX_W-1:0] cfg_index_i,
    input  logic [7:0]           cfg_data_i,
    input  logic                 accept_i,
    input  logic [7:0]           rx_byte_i,
    output logic                 push_o,
    output sfd_result_t          result_o
);

    `include "serial_frame_decoder_assert.svh"

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_FN_HI  = 3'd1,
        PH_FN_LO  = 3'd2,
        PH_LEN_HI = 3'd3,
        PH_LEN_LO = 3'd4,
        PH_DATA   = 3'd5,
        PH_CHECK  = 3'd6
    } phase_t;

    localparam logic [15:0] MaxLen = 16'(MAX_PAYLOAD);

    phase_t      phase_reg, phase_next;
    logic [15:0] func_reg, func_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] cnt_reg, cnt_next;
    logic [7:0]  csum_reg, csum_next;
    logic [7:0]  start_reg;
    logic [7:0]  seed_reg;
    logic [15:0] len_full;
    logic [15:0] cnt_inc;
    logic        too_long;

    assign len_full = {len_reg[15:8], rx_byte_i};
    assign cnt_inc  = cnt_reg + 16'd1;
    assign too_long = len_reg > MaxLen;

    always_comb begin
        phase_next = phase_reg;
        func_next  = func_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        csum_next  = csum_reg;
        push_o     = 1'b0;
        result_o   = '{
            result_kind:    KIND_PAYLOAD,
            data_byte:      8'd0,
            byte_index:     7'd0,
            function_code:  func_reg,
            payload_length: len_reg,
            frame_ok:       1'b0,
            too_long:       1'b0
        };
        if (accept_i) begin
            case (phase_reg)
                PH_FN_HI: begin
                    func_next  = {rx_byte_i, 8'd0};
                    csum_next  = csum_reg ^ rx_byte_i;
                    phase_next = PH_FN_LO;
                end
                PH_FN_LO: begin
                    func_next  = {func_reg[15:8], rx_byte_i};
                    csum_next  = csum_reg ^ rx_byte_i;
                    phase_next = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    len_next   = {rx_byte_i, 8'd0};
                    csum_next  = csum_reg ^ rx_byte_i;
                    phase_next = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    len_next   = len_full;
                    csum_next  = csum_reg ^ rx_byte_i;
                    cnt_next   = 16'd0;
                    phase_next = (len_full != 16'd0) ? PH_DATA : PH_CHECK;
                end
                PH_DATA: begin
                    csum_next = csum_reg ^ rx_byte_i;
                    if (cnt_reg < MaxLen) begin
                        push_o              = 1'b1;
                        result_o.data_byte  = rx_byte_i;
                        result_o.byte_index = cnt_reg[6:0];
                    end
                    cnt_next = cnt_inc;
                    if (cnt_inc >= len_reg) begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    push_o               = 1'b1;
                    result_o.result_kind = KIND_FRAME_END;
                    result_o.too_long    = too_long;
                    result_o.frame_ok    = (csum_reg == rx_byte_i) && !too_long;
                    phase_next           = PH_IDLE;
                end
                default: begin
                    func_next = 16'd0;
                    len_next  = 16'd0;
                    cnt_next  = 16'd0;
                    if (rx_byte_i == start_reg) begin
                        csum_next  = seed_reg;
                        phase_next = PH_FN_HI;
                    end else begin
                        phase_next = PH_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            func_reg  <= 16'd0;
            len_reg   <= 16'd0;
            cnt_reg   <= 16'd0;
            csum_reg  <= CHECKSUM_SEED_RST;
            start_reg <= START_BYTE_RST;
            seed_reg  <= CHECKSUM_SEED_RST;
        end else begin
            phase_reg <= phase_next;
            func_reg  <= func_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
            csum_reg  <= csum_next;
            if (cfg_we_i && (cfg_index_i == REG_START_BYTE)) begin
                start_reg <= cfg_data_i;
            end
            if (cfg_we_i && (cfg_index_i == REG_CHECKSUM_SEED)) begin
                seed_reg <= cfg_data_i;
            end
        end
    end

    `SFD_ASSERT_IMPLIES(a_push_needs_beat, aclk, aresetn, push_o, accept_i, "result without input beat")
    `SFD_ASSERT_IMPLIES(a_data_emits, aclk, aresetn, accept_i && (phase_reg == PH_DATA) && (cnt_reg < MaxLen), push_o, "payload byte dropped")
    `SFD_ASSERT_NEXT(a_check_closes, aclk, aresetn, accept_i && (phase_reg == PH_CHECK), phase_reg == PH_IDLE, "frame not closed after checksum")

endmodule

>>> rtl/core/sfd_queue.sv
// Short result queue between the parser and the output stage.
`timescale 1ns / 1ps

module sfd_queue
    import sfd_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push_i,
    input  sfd_result_t data_i,
    output logic        full_o,
    input  logic        pop_i,
    output logic        valid_o,
    output sfd_result_t data_o
);

    `include "serial_frame_decoder_assert.svh"

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    sfd_result_t     mem_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;

    assign full_o  = count_reg == FullCnt;
    assign valid_o = count_reg != '0;
    assign data_o  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push_i) begin
            mem_reg[wr_ptr_reg] <= data_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push_i) begin
                wr_ptr_reg <= (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop_i) begin
                rd_ptr_reg <= (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push_i && !pop_i) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop_i && !push_i) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `SFD_ASSERT_IMPLIES(a_push_has_room, aclk, aresetn, push_i, count_reg < FullCnt, "queue overflow")
    `SFD_ASSERT_IMPLIES(a_pop_has_entry, aclk, aresetn, pop_i, count_reg != '0, "queue underflow")
    `SFD_ASSERT_NEXT(a_count_grows, aclk, aresetn, push_i && !pop_i, count_reg == $past(count_reg) + 1'b1, "queue count lost a push")

endmodule

>>> rtl/core/sfd_back.sv
// Back end: output register that packs queued results into master-side beats.
`timescale 1ns / 1ps

module sfd_back
    import sfd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid_i,
    input  sfd_result_t        q_data_i,
    output logic               q_pop_o,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,
    output logic               m_tuser
);

    logic               out_valid_reg;
    logic [TDATA_W-1:0] out_data_reg;
    logic               out_user_reg;
    logic [TDATA_W-1:0] packed_data;

    assign packed_data = {
        7'd0,
        q_data_i.too_long,
        q_data_i.frame_ok,
        q_data_i.payload_length,
        q_data_i.function_code,
        q_data_i.byte_index,
        q_data_i.data_byte
    };

    assign q_pop_o  = q_valid_i && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    always_ff @(posedge aclk) begin
        if (q_pop_o) begin
            out_data_reg <= packed_data;
            out_user_reg <= q_data_i.result_kind;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (q_pop_o) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule
